// ===== rtl/core/signed_integer_to_radix_digits_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter.
// Each macro expands to a clocked concurrent assertion, or to nothing when
// ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef ASSERT_OFF
`define SIRD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sird assertion failed");
`define SIRD_ASSERT(label, prop) `SIRD_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define SIRD_ASSERT_CLK(label, clk, rst_n, prop)
`define SIRD_ASSERT(label, prop)
`endif

`endif

// ===== rtl/core/sird_pkg.sv =====
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types and constants of the signed integer to radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sird_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned MAX_RADIX_DEF = 16;
  localparam int unsigned MIN_RADIX     = 2;

  // Divider: bits of the dividend retired per cycle, and divider steps per digit.
  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Digit stack: radix two gives the most digits, one per magnitude bit.
  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned SP_W       = $clog2(MAX_DIGITS + 1);

  localparam int unsigned FIFO_DEPTH = 2;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned RADIX_W    = 5;

  localparam logic [RADIX_W-1:0]    RADIX_RST    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYM_HIGH_RST = 64'h4645_4443_4241_3938;

  localparam logic [SYM_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'h2B;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX    = 2'd0,
    CFG_SYM_LOW  = 2'd1,
    CFG_SYM_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } back_state_e;

  // One conversion job handed from the front to the back.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/signed_integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Writes signed 32-bit values out as text in a configurable radix.
// ----------------------------------------------------------------------------
// Each input item on the s_axis channel carries one signed value. For it the
// m_axis channel gives one item per character: a minus sign first when the
// value is negative, then the digit symbols, most significant first, with
// tlast high on the final character. Zero gives symbol zero alone.
// The radix (saturated to MAX_RADIX) and the sixteen symbol bytes are set
// through the write port. When the radix is below two, or a symbol in use is
// a plus or minus sign, or two symbols in use are equal, an item is taken and
// gives no output.
// The back end divides each digit out of the magnitude with a divider that
// retires eight quotient bits a cycle, then emits one character per cycle
// while the receiver keeps up. A two-entry job queue lets the front keep
// accepting items while the back works. When m_axis_tready is low the output
// register holds its character and the back end waits; the queue then fills
// and s_axis_tready drops. Reset restores radix ten and the symbols 0-9, A-F,
// and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits #(
  parameter int unsigned MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Input stream: tdata holds value (32 bits, signed).
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  wire logic signed [sird_pkg::VALUE_W-1:0]    s_axis_tdata,
  // Output stream: tdata holds symbol (8 bits); tlast marks the last char.
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output logic [sird_pkg::SYM_W-1:0]                  m_axis_tdata,
  output logic                                        m_axis_tlast,
  // Configuration write port.
  input  wire logic                                   cfg_we_i,
  input  wire logic [sird_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [sird_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import sird_pkg::*;

  localparam int unsigned REM_W = $clog2(MAX_RADIX) + 1;

  logic [RADIX_W-1:0]    radix_q;
  logic [CFG_DATA_W-1:0] sym_low_q;
  logic [CFG_DATA_W-1:0] sym_high_q;

  logic [REM_W-1:0]                eff_radix;
  logic [2*CFG_DATA_W-1:0]         sym_all;
  logic [MAX_RADIX-1:0][SYM_W-1:0] symbols;

  logic fifo_ready, fifo_push, fifo_valid, fifo_pop;
  job_t front_job, back_job;

  // Configuration registers. Writes to an index outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RST;
      sym_low_q  <= SYM_LOW_RST;
      sym_high_q <= SYM_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_RADIX:    radix_q    <= cfg_wdata_i[RADIX_W-1:0];
        CFG_SYM_LOW:  sym_low_q  <= cfg_wdata_i;
        CFG_SYM_HIGH: sym_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A programmed radix above MAX_RADIX saturates.
  assign eff_radix = (radix_q > RADIX_W'(MAX_RADIX)) ? REM_W'(MAX_RADIX)
                                                     : radix_q[REM_W-1:0];

  // Symbol k sits in byte k of the two symbol registers taken together.
  assign sym_all = {sym_high_q, sym_low_q};
  always_comb begin
    for (int unsigned k = 0; k < MAX_RADIX; k++) begin
      symbols[k] = sym_all[SYM_W*k +: SYM_W];
    end
  end

  sird_front #(
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .radix_i      (eff_radix),
    .symbols_i    (symbols),
    .fifo_ready_i (fifo_ready),
    .push_o       (fifo_push),
    .job_o        (front_job)
  );

  sird_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_job),
    .ready_o (fifo_ready),
    .valid_o (fifo_valid),
    .pop_i   (fifo_pop),
    .data_o  (back_job)
  );

  sird_back #(
    .MAX_RADIX (MAX_RADIX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (eff_radix),
    .symbols_i    (symbols),
    .job_valid_i  (fifo_valid),
    .job_i        (back_job),
    .job_pop_o    (fifo_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_symbol_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sird_front.sv =====
// ----------------------------------------------------------------------------
// sird_front
// Accepts input items, checks the digit base and turns each value into a
// sign and an unsigned magnitude. Items under an invalid base are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_front #(
  parameter  int unsigned MAX_RADIX = sird_pkg::MAX_RADIX_DEF,
  localparam int unsigned REM_W     = $clog2(MAX_RADIX) + 1
) (
  input  wire logic                                         in_valid_i,
  output logic                                              in_ready_o,
  input  wire logic signed [sird_pkg::VALUE_W-1:0]          in_value_i,
  input  wire logic [REM_W-1:0]                             radix_i,
  input  wire logic [MAX_RADIX-1:0][sird_pkg::SYM_W-1:0]    symbols_i,
  input  wire logic                                         fifo_ready_i,
  output logic                                              push_o,
  output sird_pkg::job_t                                    job_o
);
  import sird_pkg::*;

  logic               base_ok;
  logic [VALUE_W-1:0] raw;

  // Every symbol in use must differ from the sign characters and from all
  // other symbols in use. A pair is in use when its higher index is.
  always_comb begin
    base_ok = (radix_i >= REM_W'(MIN_RADIX));
    for (int unsigned a = 0; a < MAX_RADIX; a++) begin
      if (REM_W'(a) < radix_i) begin
        if (symbols_i[a] == PLUS_CHAR || symbols_i[a] == MINUS_CHAR) begin
          base_ok = 1'b0;
        end
      end
      for (int unsigned b = a + 1; b < MAX_RADIX; b++) begin
        if (REM_W'(b) < radix_i && symbols_i[a] == symbols_i[b]) begin
          base_ok = 1'b0;
        end
      end
    end
  end

  // The magnitude is taken as unsigned, so the most negative value is exact.
  assign raw        = in_value_i;
  assign job_o.neg  = raw[VALUE_W-1];
  assign job_o.mag  = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
  assign in_ready_o = fifo_ready_i;
  assign push_o     = in_valid_i && fifo_ready_i && base_ok;

endmodule

`default_nettype wire

// ===== rtl/core/sird_fifo.sv =====
// ----------------------------------------------------------------------------
// sird_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sird_pkg::job_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output sird_pkg::job_t      data_o
);
  import sird_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sird_back.sv =====
// ----------------------------------------------------------------------------
// sird_back
// Divides each magnitude down by the radix into a digit stack, then emits
// the optional minus sign and the digits, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_integer_to_radix_digits_defines.svh"

module sird_back #(
  parameter  int unsigned MAX_RADIX = sird_pkg::MAX_RADIX_DEF,
  localparam int unsigned REM_W     = $clog2(MAX_RADIX) + 1
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic [REM_W-1:0]                          radix_i,
  input  wire logic [MAX_RADIX-1:0][sird_pkg::SYM_W-1:0] symbols_i,
  input  wire logic                                      job_valid_i,
  input  wire sird_pkg::job_t                            job_i,
  output logic                                           job_pop_o,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output logic [sird_pkg::SYM_W-1:0]                     out_symbol_o,
  output logic                                           out_last_o
);
  import sird_pkg::*;

  localparam int unsigned DIGIT_W = REM_W - 1;

  back_state_e        state_q, state_d;
  logic               neg_q;
  logic [VALUE_W-1:0] quo_q;
  logic [REM_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;
  logic [SP_W-1:0]    sp_q;
  logic [DIGIT_W-1:0] stack_q [MAX_DIGITS];
  logic               out_valid_q;
  logic [SYM_W-1:0]   out_sym_q;
  logic               out_last_q;

  logic               load_ok;
  logic               last_step;
  logic               job_zero;
  logic [VALUE_W-1:0] div_quo;
  logic [REM_W-1:0]   div_rem;
  logic [SP_W-1:0]    sp_m1;
  logic [DIGIT_W-1:0] top_digit;

  // Control strobes.
  logic               start_job;
  logic               push_digit;
  logic [DIGIT_W-1:0] push_val;
  logic               div_run;
  logic               load_sign;
  logic               load_digit;

  assign load_ok   = !out_valid_q || out_ready_i;
  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
  assign job_zero  = (job_i.mag == '0);
  assign sp_m1     = sp_q - SP_W'(1);
  assign top_digit = stack_q[sp_m1[IDX_W-1:0]];

  // Restoring division, DIV_BITS quotient bits per cycle. The quotient
  // replaces the dividend bit by bit in the same register.
  always_comb begin
    logic [REM_W-1:0] trial;
    logic             qbit;
    div_quo = quo_q;
    div_rem = rem_q;
    for (int unsigned i = 0; i < DIV_BITS; i++) begin
      trial = {div_rem[REM_W-2:0], div_quo[VALUE_W-1]};
      qbit  = (trial >= radix_i);
      if (qbit) begin
        trial = trial - radix_i;
      end
      div_rem = trial;
      div_quo = {div_quo[VALUE_W-2:0], qbit};
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_zero ? BK_EMIT : BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step && div_quo == '0) begin
          state_d = neg_q ? BK_SIGN : BK_EMIT;
        end
      end
      BK_SIGN: begin
        if (load_ok) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load_ok && sp_q == SP_W'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    start_job  = 1'b0;
    push_digit = 1'b0;
    push_val   = div_rem[DIGIT_W-1:0];
    div_run    = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        start_job  = job_valid_i;
        push_digit = job_valid_i && job_zero;
        push_val   = '0;
      end
      BK_DIV: begin
        div_run    = 1'b1;
        push_digit = last_step;
      end
      BK_SIGN: load_sign  = load_ok;
      BK_EMIT: load_digit = load_ok;
      default: ;
    endcase
  end

  assign job_pop_o = start_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sp_q        <= '0;
      step_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push_digit) begin
        sp_q <= sp_q + SP_W'(1);
      end else if (load_digit) begin
        sp_q <= sp_m1;
      end
      if (start_job) begin
        step_q <= '0;
        neg_q  <= job_i.neg;
      end else if (div_run) begin
        step_q <= last_step ? '0 : step_q + STEP_W'(1);
      end
      if (load_sign || load_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_job) begin
      quo_q <= job_i.mag;
      rem_q <= '0;
    end else if (div_run) begin
      quo_q <= div_quo;
      rem_q <= last_step ? '0 : div_rem;
    end
    if (push_digit) begin
      stack_q[sp_q[IDX_W-1:0]] <= push_val;
    end
    if (load_sign) begin
      out_sym_q  <= MINUS_CHAR;
      out_last_q <= 1'b0;
    end else if (load_digit) begin
      out_sym_q  <= symbols_i[top_digit];
      out_last_q <= (sp_q == SP_W'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

  `SIRD_ASSERT(a_sp_bound, sp_q <= SP_W'(MAX_DIGITS))
  `SIRD_ASSERT(a_emit_has_digits, (state_q == BK_SIGN || state_q == BK_EMIT) |-> sp_q != '0)
  `SIRD_ASSERT(a_rem_below_radix, state_q == BK_DIV |-> rem_q < radix_i)

endmodule

`default_nettype wire
